[rtl/core/blc_pkg.sv]
// Package for the battery level conditioner: payload structs, the config
// struct, register index codes and reset constants. No dependencies.
`default_nettype none

package blc_pkg;

  localparam int unsigned PctW = 7;
  localparam int unsigned CntW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 7;

  localparam logic [PctW-1:0] PctMax = 7'd100;
  localparam logic [CntW-1:0] CntMax = 4'd15;

  localparam logic [PctW-1:0] StepLimitRst = 7'd3;
  localparam logic [PctW-1:0] LowEnterRst = 7'd15;
  localparam logic [PctW-1:0] LowExitRst = 7'd20;
  localparam logic [CntW-1:0] OffPollsRst = 4'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_LIMIT = 3'd0,
    CFG_LOW_ENTER  = 3'd1,
    CFG_LOW_EXIT   = 3'd2,
    CFG_OFF_POLLS  = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [8:0] raw_level;
    logic              is_charging;
    logic              on_external_power;
    logic [15:0]       battery_mv;
    logic [1:0]        charger_state;
  } in_t;

  typedef struct packed {
    logic [PctW-1:0] level_pct;
    logic            low_flag;
    logic            charging_display;
    logic            external_power;
    logic [15:0]     battery_mv_out;
    logic [1:0]      charger_state_out;
  } out_t;

  typedef struct packed {
    logic [PctW-1:0] step_limit;
    logic [PctW-1:0] enter_thr;
    logic [PctW-1:0] exit_thr;
    logic [CntW-1:0] off_polls;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/battery_level_conditioner_unit.sv]
// Top level of the battery level conditioner: config registers, input
// stage, conditioning update and result register. Uses blc_pkg,
// blc_in_stage and blc_cond.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one charger poll per
//   transfer. Result channel (out_valid/out_ready/out_data) returns exactly
//   one conditioned snapshot per poll, in order.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_wdata) writes the
//   step limit, low thresholds and off-poll count; always ready. Indexes
//   beyond the register list are dropped. Write only while idle.
// Path: each poll passes the input register, then the result register.
//   Throughput: one poll per cycle while out_ready stays high; the state
//   update is a single short pass between the two registers.
// Stall: if out_ready is low the result register holds, the input stage
//   holds its poll, and in_ready drops once both are full. A new poll is
//   still taken while a result waits, as long as the input stage is free.
// Reset (rst_n low, synchronous): both stages empty, conditioning state
//   cleared and unseeded, config registers back to their defaults
//   (step 3, enter 15, exit 20, off polls 3). The first poll after reset
//   seeds level and average directly from the clamped reading.
`default_nettype none

module battery_level_conditioner_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire blc_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output blc_pkg::out_t                      out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [blc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [blc_pkg::CfgDataW-1:0]  cfg_wdata
);

  blc_pkg::cfg_t  cfg_r;
  logic           s1_valid;
  blc_pkg::in_t   s1_data;
  logic           fire;
  blc_pkg::out_t  result;
  logic           out_valid_r, out_valid_nxt;
  blc_pkg::out_t  out_data_r;

  // ---- config registers ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_limit <= blc_pkg::StepLimitRst;
      cfg_r.enter_thr  <= blc_pkg::LowEnterRst;
      cfg_r.exit_thr   <= blc_pkg::LowExitRst;
      cfg_r.off_polls  <= blc_pkg::OffPollsRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        blc_pkg::CFG_STEP_LIMIT: cfg_r.step_limit <= cfg_wdata;
        blc_pkg::CFG_LOW_ENTER:  cfg_r.enter_thr  <= cfg_wdata;
        blc_pkg::CFG_LOW_EXIT:   cfg_r.exit_thr   <= cfg_wdata;
        blc_pkg::CFG_OFF_POLLS:  cfg_r.off_polls  <= cfg_wdata[blc_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // ---- input register ----
  blc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_take  (fire)
  );

  // A poll is processed when the result register is free or draining.
  assign fire = s1_valid && (!out_valid_r || out_ready);

  // ---- conditioning state and update ----
  blc_cond u_cond (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .fire   (fire),
    .item   (s1_data),
    .result (result)
  );

  // ---- result register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/blc_in_stage.sv]
// Input register stage of the battery level conditioner.
// Uses blc_pkg for the input payload struct.
`default_nettype none

module blc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire blc_pkg::in_t in_data,
  output logic            s1_valid,
  output blc_pkg::in_t    s1_data,
  input  wire logic       s1_take
);

  logic         valid_r, valid_nxt;
  blc_pkg::in_t data_r;

  // Free when empty or when the held item moves on this cycle.
  assign in_ready = !valid_r || s1_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

`default_nettype wire

[rtl/core/blc_cond.sv]
// Conditioning state and per-poll update: clamp, average, slew limit,
// low latch and charging debounce. Uses blc_pkg for payload and config types.
`default_nettype none

module blc_cond (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire blc_pkg::cfg_t cfg,
  input  wire logic         fire,
  input  wire blc_pkg::in_t  item,
  output blc_pkg::out_t     result
);

  localparam int unsigned PctW = blc_pkg::PctW;
  localparam int unsigned CntW = blc_pkg::CntW;

  logic [PctW-1:0] level_r, level_nxt;
  logic [PctW-1:0] avg_r, avg_nxt;
  logic            low_r, low_nxt;
  logic            chg_r, chg_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            seeded_r;

  logic [PctW-1:0] raw;
  logic            powered;
  logic [8:0]      avg_sum;
  logic [PctW-1:0] tgt;
  logic [PctW-1:0] diff;
  logic [CntW-1:0] cnt_inc;

  always_comb begin
    // clamp: negative to zero, above full scale to full scale
    if (item.raw_level[8]) begin
      raw = '0;
    end else if (item.raw_level[7:0] > {1'b0, blc_pkg::PctMax}) begin
      raw = blc_pkg::PctMax;
    end else begin
      raw = item.raw_level[PctW-1:0];
    end
    powered = item.is_charging || item.on_external_power;

    avg_sum = {avg_r, 1'b0} + {2'b00, avg_r} + {2'b00, raw};
    avg_nxt = avg_sum[8:2];

    tgt = avg_nxt;
    if (!powered && (tgt > level_r)) begin
      tgt = level_r;
    end

    level_nxt = tgt;
    if (tgt > level_r) begin
      diff = tgt - level_r;
      if (diff > cfg.step_limit) begin
        level_nxt = level_r + cfg.step_limit;
      end
    end else begin
      diff = level_r - tgt;
      if (diff > cfg.step_limit) begin
        level_nxt = level_r - cfg.step_limit;
      end
    end

    low_nxt = low_r;
    if (powered) begin
      low_nxt = 1'b0;
    end else if (level_nxt <= cfg.enter_thr) begin
      low_nxt = 1'b1;
    end else if (level_nxt >= cfg.exit_thr) begin
      low_nxt = 1'b0;
    end

    cnt_inc = (cnt_r < blc_pkg::CntMax) ? cnt_r + 1'b1 : cnt_r;
    chg_nxt = chg_r;
    cnt_nxt = cnt_r;
    if (item.is_charging) begin
      chg_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (!item.on_external_power) begin
      chg_nxt = 1'b0;
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_inc;
      if (cnt_inc >= cfg.off_polls) begin
        chg_nxt = 1'b0;
      end
    end

    // first poll seeds straight from the clamped reading
    if (!seeded_r) begin
      level_nxt = raw;
      avg_nxt   = raw;
      chg_nxt   = item.is_charging;
      low_nxt   = !powered && (raw <= cfg.enter_thr);
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      avg_r    <= '0;
      low_r    <= 1'b0;
      chg_r    <= 1'b0;
      cnt_r    <= '0;
      seeded_r <= 1'b0;
    end else if (fire) begin
      level_r  <= level_nxt;
      avg_r    <= avg_nxt;
      low_r    <= low_nxt;
      chg_r    <= chg_nxt;
      cnt_r    <= cnt_nxt;
      seeded_r <= 1'b1;
    end
  end

  assign result.level_pct         = level_nxt;
  assign result.low_flag          = low_nxt;
  assign result.charging_display  = chg_nxt;
  assign result.external_power    = item.on_external_power;
  assign result.battery_mv_out    = item.battery_mv;
  assign result.charger_state_out = item.charger_state;

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for battery_level_conditioner_unit: random-stall
// valid/ready traffic, register phases and an in-house snapshot predictor.
// Depends on blc_pkg and the RTL of battery_level_conditioner_unit.
`timescale 1ns / 100ps

module tb;

  // Run shape. Each phase is one register setting; the directed script
  // runs in the reset setting, the random phases after it.
  localparam int unsigned NumRegs = 4;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseItems = 85;
  localparam int unsigned TailCycles = 6;    // result pipe is 2 deep, plus margin
  localparam int unsigned StallLimit = 1000; // cycles with no transfer at all

  typedef enum int {
    RUN_CHARGE,
    RUN_MAINS,
    RUN_BATTERY,
    RUN_NOISE
  } run_kind_t;

  // One line of the directed script. When typed is set, snap holds the
  // snapshot typed in by hand; otherwise the predictor decides.
  typedef struct packed {
    blc_pkg::in_t  poll;
    logic          typed;
    blc_pkg::out_t snap;
  } script_row_t;

  typedef struct packed {
    logic [blc_pkg::CfgDataW-1:0] step_v;
    logic [blc_pkg::CfgDataW-1:0] enter_v;
    logic [blc_pkg::CfgDataW-1:0] leave_v;
    logic [blc_pkg::CfgDataW-1:0] off_v;
  } reg_set_t;

  localparam int unsigned NumScript = 20;
  localparam script_row_t Script [NumScript] = '{
    // first poll after reset seeds from the clamped reading: most negative
    // raw value clamps to 0, unpowered at 0 percent latches low
    '{'{-9'sd256, 1'b0, 1'b0, 16'h0000, 2'd0}, 1'b1,
      '{7'd0, 1'b1, 1'b0, 1'b0, 16'h0000, 2'd0}},
    '{'{9'sd255, 1'b1, 1'b1, 16'hFFFF, 2'd3}, 1'b0, '0}, // top clamp, charging
    '{'{9'sd101, 1'b0, 1'b1, 16'h0001, 2'd2}, 1'b0, '0}, // just above 100
    '{'{9'sd100, 1'b0, 1'b1, 16'h8000, 2'd1}, 1'b0, '0}, // mains, counting
    '{'{9'sd100, 1'b0, 1'b1, 16'h7FFF, 2'd2}, 1'b0, '0}, // indicator drops here
    '{'{9'sd100, 1'b0, 1'b1, 16'h5A5A, 2'd0}, 1'b0, '0},
    '{'{9'sd0, 1'b0, 1'b0, 16'hA5A5, 2'd0}, 1'b0, '0},   // unpowered
    '{'{-9'sd1, 1'b0, 1'b0, 16'h0F0F, 2'd1}, 1'b0, '0},
    '{'{9'sd50, 1'b1, 1'b0, 16'hF0F0, 2'd2}, 1'b0, '0},  // charging w/o mains
    '{'{9'sd50, 1'b0, 1'b0, 16'h1234, 2'd0}, 1'b0, '0},  // power gone: drops now
    '{'{9'sd100, 1'b1, 1'b1, 16'h4321, 2'd2}, 1'b0, '0},
    '{'{9'sd100, 1'b0, 1'b1, 16'h00FF, 2'd3}, 1'b0, '0},
    '{'{9'sd100, 1'b1, 1'b1, 16'hFF00, 2'd2}, 1'b0, '0}, // charge clears count
    '{'{9'sd100, 1'b0, 1'b0, 16'h0000, 2'd0}, 1'b0, '0}, // target held to level
    '{'{-9'sd128, 1'b0, 1'b0, 16'hFFFF, 2'd0}, 1'b0, '0},
    '{'{9'sd20, 1'b0, 1'b0, 16'h0002, 2'd0}, 1'b0, '0},
    '{'{9'sd15, 1'b0, 1'b0, 16'h0004, 2'd0}, 1'b0, '0},
    '{'{9'sd10, 1'b0, 1'b0, 16'h0008, 2'd1}, 1'b0, '0},
    '{'{9'sd10, 1'b0, 1'b1, 16'h0010, 2'd2}, 1'b0, '0}, // mains clears low
    '{'{9'sd127, 1'b0, 1'b0, 16'h0020, 2'd3}, 1'b0, '0}
  };

  // Fixed register phases: no-limit step with off polls of 0, frozen level
  // with enter above exit and a masked off count of 15, then the extremes.
  localparam reg_set_t FixedSets [4] = '{
    '{7'd127, 7'd40, 7'd60, 7'd0},
    '{7'd0, 7'd100, 7'd0, 7'h7F},
    '{7'd1, 7'd0, 7'd127, 7'd1},
    '{7'd100, 7'd127, 7'd100, 7'd15}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  blc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  blc_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [blc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [blc_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // predictor copy of the registers and the conditioning state
  logic [blc_pkg::PctW-1:0] lim_step = blc_pkg::StepLimitRst;
  logic [blc_pkg::PctW-1:0] enter_pct = blc_pkg::LowEnterRst;
  logic [blc_pkg::PctW-1:0] exit_pct = blc_pkg::LowExitRst;
  logic [blc_pkg::CntW-1:0] off_limit = blc_pkg::OffPollsRst;
  logic [blc_pkg::PctW-1:0] shown_lvl = '0;
  logic [blc_pkg::PctW-1:0] avg_lvl = '0;
  logic low_latched = 1'b0;
  logic chg_shown = 1'b0;
  logic [blc_pkg::CntW-1:0] off_run = '0;
  logic seeded_q = 1'b0;

  blc_pkg::out_t expected_snaps [$];
  blc_pkg::out_t exp_snap;
  int unsigned mismatches = 0;
  int unsigned n_polls = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_snaps = 0;
  int unsigned n_low = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_wait = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  battery_level_conditioner_unit DUT (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_wdata
  );

  always #5 clk = ~clk;

  // Predictor: one poll in, the snapshot it should produce out.
  function automatic blc_pkg::out_t condition_poll(blc_pkg::in_t p);
    logic [blc_pkg::PctW-1:0] raw;
    logic [blc_pkg::PctW-1:0] tgt;
    logic powered;
    blc_pkg::out_t r;
    if (p.raw_level[8]) begin
      raw = '0;
    end else if (p.raw_level[7:0] > blc_pkg::PctMax) begin
      raw = blc_pkg::PctMax;
    end else begin
      raw = p.raw_level[blc_pkg::PctW-1:0];
    end
    powered = p.is_charging | p.on_external_power;
    if (!seeded_q) begin
      shown_lvl = raw;
      avg_lvl = raw;
      chg_shown = p.is_charging;
      low_latched = !powered && (raw <= enter_pct);
      off_run = '0;
      seeded_q = 1'b1;
    end else begin
      avg_lvl = blc_pkg::PctW'((32'(avg_lvl) * 3 + 32'(raw)) / 4);
      tgt = avg_lvl;
      // on battery the shown level never climbs
      if (!powered && tgt > shown_lvl) tgt = shown_lvl;
      if (tgt > shown_lvl) begin
        shown_lvl = (tgt - shown_lvl > lim_step) ? shown_lvl + lim_step : tgt;
      end else begin
        shown_lvl = (shown_lvl - tgt > lim_step) ? shown_lvl - lim_step : tgt;
      end
      // enter test first, so overlapping thresholds latch
      if (powered) begin
        low_latched = 1'b0;
      end else if (shown_lvl <= enter_pct) begin
        low_latched = 1'b1;
      end else if (shown_lvl >= exit_pct) begin
        low_latched = 1'b0;
      end
      if (p.is_charging) begin
        chg_shown = 1'b1;
        off_run = '0;
      end else if (!p.on_external_power) begin
        chg_shown = 1'b0;
        off_run = '0;
      end else begin
        if (off_run < blc_pkg::CntMax) off_run = off_run + 1'b1;
        if (off_run >= off_limit) chg_shown = 1'b0;
      end
    end
    r.level_pct = shown_lvl;
    r.low_flag = low_latched;
    r.charging_display = chg_shown;
    r.external_power = p.on_external_power;
    r.battery_mv_out = p.battery_mv;
    r.charger_state_out = p.charger_state;
    return r;
  endfunction

  // Random poll shaped by the kind of run it belongs to.
  function automatic blc_pkg::in_t random_poll(run_kind_t kind);
    blc_pkg::in_t p;
    p.battery_mv = 16'($urandom);
    p.charger_state = 2'($urandom);
    if (kind == RUN_NOISE || $urandom_range(0, 5) == 0) begin
      p.raw_level = 9'($urandom);
    end else if (kind == RUN_BATTERY && $urandom_range(0, 1) == 1) begin
      p.raw_level = 9'($urandom_range(0, 30));  // drag the level into low range
    end else begin
      p.raw_level = 9'($urandom_range(0, 100));
    end
    case (kind)
      RUN_CHARGE: begin
        p.is_charging = 1'b1;
        p.on_external_power = ($urandom_range(0, 3) != 0);
      end
      RUN_MAINS: begin
        // mostly idle on mains, with rare charge blips to restart the count
        p.is_charging = ($urandom_range(0, 11) == 0);
        p.on_external_power = 1'b1;
      end
      RUN_BATTERY: begin
        p.is_charging = 1'b0;
        p.on_external_power = 1'b0;
      end
      default: begin
        p.is_charging = 1'($urandom);
        p.on_external_power = 1'($urandom);
      end
    endcase
    return p;
  endfunction

  // Input channel: optional idle gap, then hold valid until the transfer.
  // Returns at the edge of the transfer with valid still high.
  task automatic send_poll(input blc_pkg::in_t p, input logic typed,
                           input blc_pkg::out_t snap);
    int unsigned gap;
    blc_pkg::out_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    pred = condition_poll(p);
    expected_snaps.push_back(typed ? snap : pred);
    n_polls++;
  endtask

  // Stop sending and wait for every outstanding snapshot.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_snaps.size() != 0);
  endtask

  // Config write; valid is left high so back-to-back writes stay clean.
  task automatic write_reg(input logic [blc_pkg::CfgIdxW-1:0] idx,
                           input logic [blc_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      blc_pkg::CFG_STEP_LIMIT: lim_step = val[blc_pkg::PctW-1:0];
      blc_pkg::CFG_LOW_ENTER:  enter_pct = val[blc_pkg::PctW-1:0];
      blc_pkg::CFG_LOW_EXIT:   exit_pct = val[blc_pkg::PctW-1:0];
      blc_pkg::CFG_OFF_POLLS:  off_limit = val[blc_pkg::CntW-1:0];
      default: ;  // beyond the list: dropped
    endcase
    n_cfg_writes++;
  endtask

  // Full register set, in a varied order, with one write to an unused index.
  task automatic program_regs(input reg_set_t rs, input int unsigned ph);
    write_reg(blc_pkg::CfgIdxW'(NumRegs + ph % ((1 << blc_pkg::CfgIdxW) - NumRegs)),
              blc_pkg::CfgDataW'($urandom));
    if ($urandom_range(0, 1) == 1) begin
      write_reg(blc_pkg::CFG_OFF_POLLS, rs.off_v);
      write_reg(blc_pkg::CFG_STEP_LIMIT, rs.step_v);
    end else begin
      write_reg(blc_pkg::CFG_STEP_LIMIT, rs.step_v);
      write_reg(blc_pkg::CFG_OFF_POLLS, rs.off_v);
    end
    write_reg(blc_pkg::CFG_LOW_EXIT, rs.leave_v);
    write_reg(blc_pkg::CFG_LOW_ENTER, rs.enter_v);
    cfg_valid <= 1'b0;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      mismatches++;
    end
  endtask

  // Result channel: random stall per snapshot, checked at each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (out_ready && out_valid) begin
      n_snaps++;
      if (out_data.low_flag) n_low++;
      if (expected_snaps.size() == 0) begin
        $display("%0t: snapshot with none expected, expected none actual %p",
                 $time, out_data);
        mismatches++;
      end else begin
        exp_snap = expected_snaps.pop_front();
        cmp_field("level_pct", 16'(exp_snap.level_pct), 16'(out_data.level_pct));
        cmp_field("low_flag", 16'(exp_snap.low_flag), 16'(out_data.low_flag));
        cmp_field("charging_display", 16'(exp_snap.charging_display),
                  16'(out_data.charging_display));
        cmp_field("external_power", 16'(exp_snap.external_power),
                  16'(out_data.external_power));
        cmp_field("battery_mv_out", exp_snap.battery_mv_out, out_data.battery_mv_out);
        cmp_field("charger_state_out", 16'(exp_snap.charger_state_out),
                  16'(out_data.charger_state_out));
      end
      if ($urandom_range(0, 29) == 0) rx_burst <= !rx_burst;
      rx_wait <= rx_burst ? 0 : $urandom_range(0, 13);
      out_ready <= rx_burst || ($urandom_range(0, 13) == 0);
    end else if (!out_ready) begin
      if (rx_wait <= 1) begin
        out_ready <= 1'b1;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reg_set_t rs;
    run_kind_t kind;
    int unsigned run_left;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed script in the reset register setting
    for (int i = 0; i < NumScript; i++) begin
      send_poll(Script[i].poll, Script[i].typed, Script[i].snap);
    end
    settle();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph < 4) begin
        rs = FixedSets[ph];
      end else begin
        rs.step_v = blc_pkg::CfgDataW'($urandom);
        rs.enter_v = blc_pkg::CfgDataW'($urandom_range(0, 100));
        rs.leave_v = blc_pkg::CfgDataW'($urandom_range(0, 100));
        rs.off_v = blc_pkg::CfgDataW'($urandom);
      end
      program_regs(rs, ph);
      run_left = 0;
      kind = RUN_NOISE;
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        if (run_left == 0) begin
          case ($urandom_range(0, 7))
            0, 1: kind = RUN_CHARGE;
            2, 3, 4: kind = RUN_MAINS;
            5, 6: kind = RUN_BATTERY;
            default: kind = RUN_NOISE;
          endcase
          run_left = $urandom_range(1, 24);
          if ($urandom_range(0, 9) == 0) tx_burst = !tx_burst;
        end
        run_left--;
        send_poll(random_poll(kind), 1'b0, '0);
        // hold off mid-phase until the pipe drains, once for sure
        if ((ph == 3 && i == PhaseItems / 2) || $urandom_range(0, 199) == 0) settle();
      end
      settle();
    end

    repeat (TailCycles) @(posedge clk);
    $display("%0d polls in %0d register settings after %0d config writes",
             n_polls, NumPhases + 1, n_cfg_writes);
    $display("%0d snapshots checked, %0d of them with the low flag set", n_snaps, n_low);
    if (mismatches == 0 && expected_snaps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/blc_pkg.sv
rtl/core/blc_in_stage.sv
rtl/core/blc_cond.sv
rtl/core/battery_level_conditioner_unit.sv
verif/tb.sv
